// ===== hdl/sldr_pkg.sv =====
package sldr_pkg;

  // action codes of an input item
  localparam logic [2:0] ACT_TICK    = 3'd0;
  localparam logic [2:0] ACT_START   = 3'd1;
  localparam logic [2:0] ACT_STOP    = 3'd2;
  localparam logic [2:0] ACT_MANUAL  = 3'd3;
  localparam logic [2:0] ACT_THERMAL = 3'd4;

  // configuration register indexes
  localparam logic CFG_DURATION = 1'b0;
  localparam logic CFG_BASE     = 1'b1;

  // field widths
  localparam int ACTION_W = 3;
  localparam int AMOUNT_W = 11;
  localparam int DUTY_W   = 10;
  localparam int CFG_W    = 16;
  localparam int DUR_S_W  = 22;
  localparam int LEVEL_W  = 6;

  // fixed numbers of the dimming law
  localparam logic [10:0] UNIT_ONE       = 11'd1024;
  localparam logic [9:0]  TABLE_TOP      = 10'd992;
  localparam logic [31:0] SEC_FORM_LIMIT = 32'hFF_FFFF;
  localparam logic [31:0] MS_PER_S       = 32'd1000;
  localparam logic [31:0] MS_PER_MIN     = 32'd60000;
  localparam logic [31:0] S_PER_MIN      = 32'd60;

  // reset values of the registers
  localparam logic [15:0]        DURATION_RESET = 16'd15;
  localparam logic [15:0]        BASE_RESET     = 16'd1000;
  localparam logic [31:0]        DUR_MS_RESET   = 32'(15 * 60000);
  localparam logic [DUR_S_W-1:0] DUR_S_RESET    = DUR_S_W'(15 * 60);

  // serial step counts
  localparam int SEC_STEPS  = 32;
  localparam int IDX_STEPS  = LEVEL_W;
  localparam int DUTY_STEPS = 20;
  localparam int MUL_STEPS  = AMOUNT_W;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EVAL,
    ST_SEC_DIV,
    ST_IDX_DIV,
    ST_LOOKUP,
    ST_MUL,
    ST_SCALE,
    ST_DUTY_DIV,
    ST_OUT
  } state_t;

  // clamp a level or factor to one full unit
  function automatic logic [10:0] sat_unit(input logic [10:0] a);
    return (a > UNIT_ONE) ? UNIT_ONE : a;
  endfunction

  // quadratic brightness curve, entry i = min((i+2)^2 / 4, 992)
  function automatic logic [9:0] level_entry(input logic [LEVEL_W-1:0] i);
    logic [6:0]  k;
    logic [13:0] sq;
    logic [11:0] q;
    k  = 7'(i) + 7'd2;
    sq = 14'(k) * 14'(k);
    q  = sq[13:2];
    return (q > 12'(TABLE_TOP)) ? TABLE_TOP : q[9:0];
  endfunction

endpackage

// ===== hdl/sldr_evt_if.sv =====
interface sldr_evt_if;
  logic                          valid;
  logic                          ready;
  logic [sldr_pkg::ACTION_W-1:0] action;
  logic [sldr_pkg::AMOUNT_W-1:0] amount;

  modport source (output valid, output action, output amount, input ready);
  modport sink   (input valid, input action, input amount, output ready);
endinterface

// ===== hdl/sldr_res_if.sv =====
interface sldr_res_if;
  logic                        valid;
  logic                        ready;
  logic [sldr_pkg::DUTY_W-1:0] pwm_duty;
  logic                        ramp_active;

  modport source (output valid, output pwm_duty, output ramp_active, input ready);
  modport sink   (input valid, input pwm_duty, input ramp_active, output ready);
endinterface

// ===== hdl/sunrise_led_dimming_ramp.sv =====
// Sunrise LED dimmer.
// evt carries one event per item: 1 ms tick, ramp start, ramp stop, manual
// level or thermal factor (amount in 1/1024 units). res carries a new PWM duty
// and the ramp flag; ticks that fall between ramp updates, start and stop
// give no item on res. Ramp length and base update period are written through
// wr_en / wr_index / wr_data; the user must write them only while the block
// is idle, and the block does not enforce this. Manual and thermal items
// pass ST_MUL, ST_SCALE, ST_DUTY_DIV over a table level, and ST_OUT. A tick
// that ends the ramp adds ST_EVAL first; a ramp update adds ST_EVAL,
// ST_SEC_DIV once elapsed time passes 0xFFFFFF ms, ST_IDX_DIV and ST_LOOKUP.
// evt takes the next item in the cycle after a result is loaded, after start,
// stop and unused codes in the next cycle, and after a tick without update
// once ST_EVAL has ended. A shared bit-serial divider (one quotient bit per
// cycle: 6 bits for the table index, 32 for ms to seconds, 20 for the duty)
// and an 11-step bit-serial multiplier work on one item at a time.
// Reset (rst, synchronous) restores 15 minutes, a 1000 ms period, a dark lamp,
// thermal factor one and a stopped ramp; res holds no item.
// A finished result waits in an output register while res stalls; evt takes
// the next item meanwhile, and work stops only at the next result.
module sunrise_led_dimming_ramp (
  input  logic                     clk,
  input  logic                     rst,
  sldr_evt_if.sink                 evt,
  sldr_res_if.source               res,
  input  logic                     wr_en,
  input  logic                     wr_index,
  input  logic [sldr_pkg::CFG_W-1:0] wr_data
);

  sldr_pkg::state_t state, state_next;

  // ramp state and configuration
  logic [31:0]                    elapsed_ms;
  logic [31:0]                    since_ms;
  logic                           ramp_running;
  logic [10:0]                    bright_value;
  logic                           bright_from_table;
  logic [10:0]                    thermal_scale;
  logic [15:0]                    base_period;
  logic [31:0]                    dur_ms;
  logic [sldr_pkg::DUR_S_W-1:0]   dur_s;
  logic [15:0]                    period;

  // serial divider
  logic [32:0] div_rem;
  logic [31:0] div_sr;
  logic [31:0] div_den;
  logic [4:0]  div_cnt;
  logic [33:0] div_shift;
  logic [33:0] div_trial;
  logic        div_qbit;
  logic [32:0] div_rem_step;
  logic [31:0] div_sr_step;
  logic        div_last;

  // serial multiplier
  logic [21:0] mul_acc;
  logic [3:0]  mul_cnt;
  logic [11:0] mul_sum;
  logic        mul_last;
  logic [31:0] num;

  // result
  logic [sldr_pkg::DUTY_W-1:0] duty;
  logic                        res_valid;
  logic                        res_duty_active;
  logic [sldr_pkg::DUTY_W-1:0] res_duty;

  logic in_fire;
  logic out_free;
  logic load_out;
  logic upd_due;
  logic ramp_over;
  logic ms_form;

  assign in_fire   = evt.valid && evt.ready;
  assign out_free  = !res_valid || res.ready;
  assign upd_due   = ramp_running && (since_ms >= {16'd0, period});
  assign ramp_over = elapsed_ms >= dur_ms;
  assign ms_form   = elapsed_ms <= sldr_pkg::SEC_FORM_LIMIT;
  assign div_last  = (div_cnt == 5'd0);
  assign mul_last  = (mul_cnt == 4'(sldr_pkg::MUL_STEPS - 1));

  // one restoring division step
  assign div_shift    = {div_rem, div_sr[31]};
  assign div_trial    = div_shift - {2'd0, div_den};
  assign div_qbit     = !div_trial[33];
  assign div_rem_step = div_qbit ? div_trial[32:0] : div_shift[32:0];
  assign div_sr_step  = {div_sr[30:0], div_qbit};

  // one shift-add multiplication step, thermal times brightness
  assign mul_sum = {1'b0, mul_acc[21:11]} +
                   (bright_value[mul_cnt] ? {1'b0, thermal_scale} : 12'd0);

  // full product times 1023
  assign num = {mul_acc, 10'd0} - {10'd0, mul_acc};

  assign res.valid       = res_valid;
  assign res.pwm_duty    = res_duty;
  assign res.ramp_active = res_duty_active;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sldr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and handshake
  always_comb begin
    state_next = state;
    evt.ready  = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      sldr_pkg::ST_IDLE: begin
        evt.ready = 1'b1;
        if (evt.valid) begin
          unique case (evt.action)
            sldr_pkg::ACT_TICK:    state_next = sldr_pkg::ST_EVAL;
            sldr_pkg::ACT_MANUAL:  state_next = sldr_pkg::ST_MUL;
            sldr_pkg::ACT_THERMAL: state_next = sldr_pkg::ST_MUL;
            default:               state_next = sldr_pkg::ST_IDLE;
          endcase
        end
      end
      sldr_pkg::ST_EVAL: begin
        priority if (!upd_due) begin
          state_next = sldr_pkg::ST_IDLE;
        end else if (ramp_over) begin
          state_next = sldr_pkg::ST_MUL;
        end else if (ms_form) begin
          state_next = sldr_pkg::ST_IDX_DIV;
        end else begin
          state_next = sldr_pkg::ST_SEC_DIV;
        end
      end
      sldr_pkg::ST_SEC_DIV: begin
        if (div_last) state_next = sldr_pkg::ST_IDX_DIV;
      end
      sldr_pkg::ST_IDX_DIV: begin
        if (div_last) state_next = sldr_pkg::ST_LOOKUP;
      end
      sldr_pkg::ST_LOOKUP: begin
        state_next = sldr_pkg::ST_MUL;
      end
      sldr_pkg::ST_MUL: begin
        if (mul_last) state_next = sldr_pkg::ST_SCALE;
      end
      sldr_pkg::ST_SCALE: begin
        state_next = bright_from_table ? sldr_pkg::ST_DUTY_DIV : sldr_pkg::ST_OUT;
      end
      sldr_pkg::ST_DUTY_DIV: begin
        if (div_last) state_next = sldr_pkg::ST_OUT;
      end
      sldr_pkg::ST_OUT: begin
        if (out_free) begin
          load_out   = 1'b1;
          state_next = sldr_pkg::ST_IDLE;
        end
      end
      default: state_next = sldr_pkg::ST_IDLE;
    endcase
  end

  // ramp state, configuration and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed_ms        <= '0;
      since_ms          <= '0;
      ramp_running      <= 1'b0;
      bright_value      <= '0;
      bright_from_table <= 1'b0;
      thermal_scale     <= sldr_pkg::UNIT_ONE;
      base_period       <= sldr_pkg::BASE_RESET;
      dur_ms            <= sldr_pkg::DUR_MS_RESET;
      dur_s             <= sldr_pkg::DUR_S_RESET;
      period            <= sldr_pkg::BASE_RESET;
      res_valid         <= 1'b0;
    end else begin
      // configuration writes, durations kept in ms and s
      if (wr_en) begin
        unique case (wr_index)
          sldr_pkg::CFG_DURATION: begin
            dur_ms <= 32'(wr_data) * sldr_pkg::MS_PER_MIN;
            dur_s  <= sldr_pkg::DUR_S_W'(32'(wr_data) * sldr_pkg::S_PER_MIN);
          end
          sldr_pkg::CFG_BASE: base_period <= wr_data;
          default: ;
        endcase
      end

      // update period capped at one table step of the ramp
      if (dur_ms[31:6] < {10'd0, base_period}) begin
        period <= dur_ms[21:6];
      end else begin
        period <= base_period;
      end

      // input events
      if (in_fire) begin
        unique case (evt.action)
          sldr_pkg::ACT_TICK: begin
            if (elapsed_ms != '1) elapsed_ms <= elapsed_ms + 32'd1;
            if (since_ms != '1) since_ms <= since_ms + 32'd1;
          end
          sldr_pkg::ACT_START: begin
            ramp_running <= 1'b1;
            elapsed_ms   <= '0;
          end
          sldr_pkg::ACT_STOP: begin
            ramp_running <= 1'b0;
          end
          sldr_pkg::ACT_MANUAL: begin
            ramp_running      <= 1'b0;
            bright_value      <= sldr_pkg::sat_unit(evt.amount);
            bright_from_table <= 1'b0;
          end
          sldr_pkg::ACT_THERMAL: begin
            thermal_scale <= sldr_pkg::sat_unit(evt.amount);
          end
          default: ;
        endcase
      end

      // ramp update on a due tick
      if (state == sldr_pkg::ST_EVAL && upd_due) begin
        since_ms <= '0;
        if (ramp_over) begin
          ramp_running      <= 1'b0;
          bright_value      <= sldr_pkg::UNIT_ONE;
          bright_from_table <= 1'b0;
        end
      end

      // table entry becomes the brightness
      if (state == sldr_pkg::ST_LOOKUP) begin
        bright_value      <= {1'b0, sldr_pkg::level_entry(div_sr[sldr_pkg::LEVEL_W-1:0])};
        bright_from_table <= 1'b1;
      end

      // output register
      if (load_out) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // serial datapath
  always_ff @(posedge clk) begin
    // multiplier start
    if (state_next == sldr_pkg::ST_MUL && state != sldr_pkg::ST_MUL) begin
      mul_acc <= '0;
      mul_cnt <= '0;
    end

    unique case (state)
      sldr_pkg::ST_EVAL: begin
        if (ms_form) begin
          // index = elapsed * 64 / duration, elapsed below duration
          div_rem <= {1'b0, elapsed_ms};
          div_sr  <= '0;
          div_den <= dur_ms;
          div_cnt <= 5'(sldr_pkg::IDX_STEPS - 1);
        end else begin
          // seconds form, first elapsed / 1000
          div_rem <= '0;
          div_sr  <= elapsed_ms;
          div_den <= sldr_pkg::MS_PER_S;
          div_cnt <= 5'(sldr_pkg::SEC_STEPS - 1);
        end
      end
      sldr_pkg::ST_SEC_DIV: begin
        if (div_last) begin
          div_rem <= {1'b0, div_sr_step};
          div_sr  <= '0;
          div_den <= 32'(dur_s);
          div_cnt <= 5'(sldr_pkg::IDX_STEPS - 1);
        end else begin
          div_rem <= div_rem_step;
          div_sr  <= div_sr_step;
          div_cnt <= div_cnt - 5'd1;
        end
      end
      sldr_pkg::ST_IDX_DIV, sldr_pkg::ST_DUTY_DIV: begin
        div_rem <= div_rem_step;
        div_sr  <= div_sr_step;
        div_cnt <= div_cnt - 5'd1;
        if (state == sldr_pkg::ST_DUTY_DIV && div_last) begin
          duty <= div_sr_step[sldr_pkg::DUTY_W-1:0];
        end
      end
      sldr_pkg::ST_MUL: begin
        mul_acc <= {mul_sum, mul_acc[10:1]};
        mul_cnt <= mul_cnt + 4'd1;
      end
      sldr_pkg::ST_SCALE: begin
        if (bright_from_table) begin
          // duty = (num / 1024) / 992
          div_rem <= '0;
          div_sr  <= {num[29:10], 12'd0};
          div_den <= 32'(sldr_pkg::TABLE_TOP);
          div_cnt <= 5'(sldr_pkg::DUTY_STEPS - 1);
        end else begin
          duty <= num[29:20];
        end
      end
      default: ;
    endcase

    // result payload
    if (load_out) begin
      res_duty        <= duty;
      res_duty_active <= ramp_running;
    end
  end

endmodule

// ===== tb/tb_sunrise_led_dimming_ramp.sv =====
module tb_sunrise_led_dimming_ramp;

  localparam int LEVELS        = 1 << sldr_pkg::LEVEL_W;
  localparam int SETTLE_CYCLES = 150;
  localparam int HOLD_CYCLES   = 400;
  localparam int SWEEP_TICKS   = 150;
  localparam int RANDOM_ITEMS  = 240;
  localparam int MAX_REPORTS   = 10;

  // action codes the block must ignore
  localparam logic [sldr_pkg::ACTION_W-1:0] ACT_SPARE_LO = 3'd5;
  localparam logic [sldr_pkg::ACTION_W-1:0] ACT_SPARE_HI = 3'd7;

  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_NONE,
    CHK_TYPED
  } check_kind_t;

  typedef struct {
    logic [sldr_pkg::DUTY_W-1:0] duty;
    logic                        active;
  } lamp_out_t;

  typedef struct {
    bit                            is_cfg;
    logic                          cfg_index;
    logic [sldr_pkg::CFG_W-1:0]    cfg_value;
    logic [sldr_pkg::ACTION_W-1:0] action;
    logic [sldr_pkg::AMOUNT_W-1:0] amount;
    check_kind_t                   check;
    lamp_out_t                     typed_out;
  } step_row_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       wr_en;
  logic                       wr_index;
  logic [sldr_pkg::CFG_W-1:0] wr_data;

  sldr_evt_if evt_ch ();
  sldr_res_if res_ch ();

  sunrise_led_dimming_ramp dut (
    .clk      (clk),
    .rst      (rst),
    .evt      (evt_ch),
    .res      (res_ch),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  // dimmer state as predicted
  logic [31:0]                   p_elapsed;
  logic [31:0]                   p_since;
  logic                          p_running;
  logic [sldr_pkg::AMOUNT_W-1:0] p_bright;
  logic                          p_from_table;
  logic [sldr_pkg::AMOUNT_W-1:0] p_thermal;
  logic [sldr_pkg::CFG_W-1:0]    p_duration;
  logic [sldr_pkg::CFG_W-1:0]    p_base;

  lamp_out_t pending_duty[$];
  step_row_t opening_steps[$];

  int  tx_idle_pct = 0;
  int  rx_idle_pct = 0;
  bit  hold_go = 1'b0;
  int  err_count = 0;
  int  items_sent = 0;
  int  results_checked = 0;
  int  ramp_updates = 0;
  int  ramp_ends = 0;
  int  reg_writes = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void note_error(input string msg);
    err_count++;
    if (err_count <= MAX_REPORTS) $display("%s", msg);
  endfunction

  // quadratic curve: min((i+2)^2 / 4, 992)
  function automatic logic [sldr_pkg::DUTY_W-1:0] curve_level(input int unsigned i);
    int unsigned q;
    q = ((i + 2) * (i + 2)) / 4;
    return (q > sldr_pkg::TABLE_TOP) ? sldr_pkg::TABLE_TOP : sldr_pkg::DUTY_W'(q);
  endfunction

  // duty = floor(full-scale duty * factor * brightness), exact
  function automatic lamp_out_t scaled_duty();
    lamp_out_t o;
    longint unsigned num;
    longint unsigned den;
    num = ((64'd1 << sldr_pkg::DUTY_W) - 64'd1) * 64'(p_thermal) * 64'(p_bright);
    den = p_from_table ? 64'(sldr_pkg::UNIT_ONE) * 64'(sldr_pkg::TABLE_TOP)
                       : 64'(sldr_pkg::UNIT_ONE) * 64'(sldr_pkg::UNIT_ONE);
    o.duty   = sldr_pkg::DUTY_W'(num / den);
    o.active = p_running;
    return o;
  endfunction

  // apply one event to the predicted dimmer, returns 1 when it yields an item
  function automatic bit advance_dimmer(input logic [sldr_pkg::ACTION_W-1:0] act,
                                        input logic [sldr_pkg::AMOUNT_W-1:0] amt,
                                        output lamp_out_t o);
    longint unsigned dur_s;
    longint unsigned dur_ms;
    longint unsigned period;
    longint unsigned idx;
    logic [sldr_pkg::AMOUNT_W-1:0] lvl;
    o.duty   = '0;
    o.active = 1'b0;
    lvl = (amt > sldr_pkg::UNIT_ONE) ? sldr_pkg::UNIT_ONE : amt;
    case (act)
      sldr_pkg::ACT_TICK: begin
        if (p_elapsed != '1) p_elapsed++;
        if (p_since != '1) p_since++;
        if (!p_running) return 1'b0;
        dur_s  = 64'(p_duration) * 64'(sldr_pkg::S_PER_MIN);
        dur_ms = dur_s * 64'(sldr_pkg::MS_PER_S);
        period = dur_ms / 64'(LEVELS);
        if (64'(p_base) < period) period = 64'(p_base);
        if (64'(p_since) < period) return 1'b0;
        p_since = '0;
        if (64'(p_elapsed) >= dur_ms) begin
          // time is up: full manual brightness, ramp over
          p_running    = 1'b0;
          p_bright     = sldr_pkg::UNIT_ONE;
          p_from_table = 1'b0;
          ramp_ends++;
        end else begin
          if (p_elapsed <= sldr_pkg::SEC_FORM_LIMIT)
            idx = 64'(p_elapsed) * 64'(LEVELS) / dur_ms;
          else
            idx = 64'(p_elapsed / sldr_pkg::MS_PER_S) * 64'(LEVELS) / dur_s;
          if (idx >= 64'(LEVELS)) begin
            p_bright     = sldr_pkg::UNIT_ONE;
            p_from_table = 1'b0;
          end else begin
            p_bright     = sldr_pkg::AMOUNT_W'(curve_level(32'(idx)));
            p_from_table = 1'b1;
            ramp_updates++;
          end
        end
      end
      sldr_pkg::ACT_START: begin
        p_running = 1'b1;
        p_elapsed = '0;
        return 1'b0;
      end
      sldr_pkg::ACT_STOP: begin
        p_running = 1'b0;
        return 1'b0;
      end
      sldr_pkg::ACT_MANUAL: begin
        p_running    = 1'b0;
        p_bright     = lvl;
        p_from_table = 1'b0;
      end
      sldr_pkg::ACT_THERMAL: begin
        p_thermal = lvl;
      end
      default: begin
        return 1'b0;
      end
    endcase
    o = scaled_duty();
    return 1'b1;
  endfunction

  function automatic void add_event(input logic [sldr_pkg::ACTION_W-1:0] act,
                                    input logic [sldr_pkg::AMOUNT_W-1:0] amt,
                                    input check_kind_t chk,
                                    input logic [sldr_pkg::DUTY_W-1:0] duty = '0,
                                    input logic active = 1'b0);
    step_row_t r;
    r.is_cfg           = 1'b0;
    r.cfg_index        = sldr_pkg::CFG_DURATION;
    r.cfg_value        = '0;
    r.action           = act;
    r.amount           = amt;
    r.check            = chk;
    r.typed_out.duty   = duty;
    r.typed_out.active = active;
    opening_steps.push_back(r);
  endfunction

  function automatic void add_write(input logic idx,
                                    input logic [sldr_pkg::CFG_W-1:0] val);
    step_row_t r;
    r.is_cfg           = 1'b1;
    r.cfg_index        = idx;
    r.cfg_value        = val;
    r.action           = sldr_pkg::ACT_TICK;
    r.amount           = '0;
    r.check            = CHK_NONE;
    r.typed_out.duty   = '0;
    r.typed_out.active = 1'b0;
    opening_steps.push_back(r);
  endfunction

  // offer one item, predict on acceptance
  task automatic drive_item(input logic [sldr_pkg::ACTION_W-1:0] act,
                            input logic [sldr_pkg::AMOUNT_W-1:0] amt,
                            input check_kind_t chk,
                            input lamp_out_t typed_out);
    lamp_out_t o;
    bit has;
    @(negedge clk);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      evt_ch.valid = 1'b0;
      @(negedge clk);
    end
    evt_ch.valid  = 1'b1;
    evt_ch.action = act;
    evt_ch.amount = amt;
    @(posedge clk);
    while (!evt_ch.ready) @(posedge clk);
    items_sent++;
    has = advance_dimmer(act, amt, o);
    case (chk)
      CHK_MODEL: if (has) pending_duty.push_back(o);
      CHK_TYPED: pending_duty.push_back(typed_out);
      default: ;
    endcase
  endtask

  // stop offering, wait for all results and for trailing work to finish
  task automatic quiet_and_settle();
    @(negedge clk);
    evt_ch.valid = 1'b0;
    while (pending_duty.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [sldr_pkg::CFG_W-1:0] val);
    quiet_and_settle();
    @(negedge clk);
    wr_en    = 1'b1;
    wr_index = idx;
    wr_data  = val;
    @(negedge clk);
    wr_en = 1'b0;
    if (idx == sldr_pkg::CFG_DURATION) p_duration = val;
    else p_base = val;
    reg_writes++;
  endtask

  // mostly ticks so running ramps get updated, plus random events and noise
  task automatic run_random(input int count, input bit with_hold);
    logic [sldr_pkg::ACTION_W-1:0] act;
    logic [sldr_pkg::AMOUNT_W-1:0] amt;
    int unsigned pick;
    lamp_out_t unused_out;
    unused_out.duty   = '0;
    unused_out.active = 1'b0;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 62) act = sldr_pkg::ACT_TICK;
      else if (pick < 72) act = sldr_pkg::ACT_START;
      else if (pick < 75) act = sldr_pkg::ACT_STOP;
      else if (pick < 83) act = sldr_pkg::ACT_MANUAL;
      else if (pick < 93) act = sldr_pkg::ACT_THERMAL;
      else act = sldr_pkg::ACTION_W'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
      case ($urandom_range(0, 7))
        0: amt = '0;
        1: amt = sldr_pkg::UNIT_ONE;
        2: amt = '1;
        3, 4: amt = sldr_pkg::AMOUNT_W'($urandom_range(0, sldr_pkg::UNIT_ONE));
        default: amt = sldr_pkg::AMOUNT_W'($urandom_range(0, (1 << sldr_pkg::AMOUNT_W) - 1));
      endcase
      drive_item(act, amt, CHK_MODEL, unused_out);
      // long receiver stall while items keep coming
      if (with_hold && k == 3) hold_go = 1'b1;
    end
  endtask

  // result receiver with random and long stalls
  initial begin : result_sink
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_go) begin
        res_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_go = 1'b0;
      end
      res_ch.ready = ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // compare each accepted result with the oldest prediction
  always @(posedge clk) begin : result_check
    lamp_out_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (pending_duty.size() == 0) begin
        note_error($sformatf("unexpected item: duty %0d ramp_active %0b",
                             res_ch.pwm_duty, res_ch.ramp_active));
      end else begin
        want = pending_duty.pop_front();
        results_checked++;
        if (res_ch.pwm_duty !== want.duty)
          note_error($sformatf("result %0d: pwm_duty expected %0d got %0d",
                               results_checked, want.duty, res_ch.pwm_duty));
        if (res_ch.ramp_active !== want.active)
          note_error($sformatf("result %0d: ramp_active expected %0b got %0b",
                               results_checked, want.active, res_ch.ramp_active));
      end
    end
  end

  initial begin : stimulus
    lamp_out_t no_out;
    no_out.duty   = '0;
    no_out.active = 1'b0;
    evt_ch.valid  = 1'b0;
    evt_ch.action = sldr_pkg::ACT_TICK;
    evt_ch.amount = '0;
    wr_en         = 1'b0;
    wr_index      = sldr_pkg::CFG_DURATION;
    wr_data       = '0;
    p_elapsed     = '0;
    p_since       = '0;
    p_running     = 1'b0;
    p_bright      = '0;
    p_from_table  = 1'b0;
    p_thermal     = sldr_pkg::UNIT_ONE;
    p_duration    = sldr_pkg::DURATION_RESET;
    p_base        = sldr_pkg::BASE_RESET;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // opening steps: reset state, saturation, ignored codes, ramp corners
    add_event(sldr_pkg::ACT_THERMAL, sldr_pkg::UNIT_ONE, CHK_TYPED, 10'd0, 1'b0);
    add_event(sldr_pkg::ACT_MANUAL, sldr_pkg::UNIT_ONE, CHK_TYPED, 10'd1023, 1'b0);
    add_event(sldr_pkg::ACT_MANUAL, 11'd0, CHK_TYPED, 10'd0, 1'b0);
    add_event(sldr_pkg::ACT_MANUAL, 11'd2047, CHK_TYPED, 10'd1023, 1'b0);
    add_event(sldr_pkg::ACT_THERMAL, 11'd0, CHK_TYPED, 10'd0, 1'b0);
    add_event(sldr_pkg::ACT_THERMAL, 11'd2047, CHK_TYPED, 10'd1023, 1'b0);
    add_event(sldr_pkg::ACT_MANUAL, 11'd1025, CHK_TYPED, 10'd1023, 1'b0);
    add_event(sldr_pkg::ACT_MANUAL, 11'd512, CHK_MODEL);
    add_event(sldr_pkg::ACT_THERMAL, 11'd700, CHK_MODEL);
    add_event(ACT_SPARE_LO, 11'd2047, CHK_NONE);
    add_event(ACT_SPARE_HI, 11'd1365, CHK_NONE);
    add_event(sldr_pkg::ACT_TICK, 11'd0, CHK_NONE);
    add_event(sldr_pkg::ACT_STOP, 11'd0, CHK_NONE);
    add_event(sldr_pkg::ACT_START, 11'd682, CHK_NONE);
    add_event(sldr_pkg::ACT_TICK, 11'd2047, CHK_NONE);
    // zero duration: first tick of a running ramp ends it
    add_write(sldr_pkg::CFG_DURATION, 16'd0);
    add_event(sldr_pkg::ACT_THERMAL, sldr_pkg::UNIT_ONE, CHK_MODEL);
    add_event(sldr_pkg::ACT_TICK, 11'd0, CHK_TYPED, 10'd1023, 1'b0);
    // zero base period: every running tick updates
    add_write(sldr_pkg::CFG_DURATION, 16'd1);
    add_write(sldr_pkg::CFG_BASE, 16'd0);
    add_event(sldr_pkg::ACT_START, 11'd0, CHK_NONE);
    add_event(sldr_pkg::ACT_TICK, 11'd0, CHK_MODEL);
    add_event(sldr_pkg::ACT_TICK, 11'd0, CHK_MODEL);
    add_event(sldr_pkg::ACT_THERMAL, 11'd2047, CHK_MODEL);
    add_event(sldr_pkg::ACT_MANUAL, 11'd300, CHK_MODEL);
    add_event(sldr_pkg::ACT_TICK, 11'd0, CHK_NONE);
    add_event(sldr_pkg::ACT_START, 11'd0, CHK_NONE);
    add_event(sldr_pkg::ACT_STOP, 11'd0, CHK_NONE);

    // sender idles less than receiver
    tx_idle_pct = 30;
    rx_idle_pct = 55;
    foreach (opening_steps[i]) begin
      if (opening_steps[i].is_cfg)
        write_reg(opening_steps[i].cfg_index, opening_steps[i].cfg_value);
      else
        drive_item(opening_steps[i].action, opening_steps[i].amount,
                   opening_steps[i].check, opening_steps[i].typed_out);
    end

    // one-minute sunrise with an update on every tick
    write_reg(sldr_pkg::CFG_DURATION, 16'd1);
    write_reg(sldr_pkg::CFG_BASE, 16'd1);
    drive_item(sldr_pkg::ACT_START, '0, CHK_MODEL, no_out);
    repeat (SWEEP_TICKS)
      drive_item(sldr_pkg::ACT_TICK, sldr_pkg::AMOUNT_W'($urandom_range(0, 2047)),
                 CHK_MODEL, no_out);

    // random events, short update period
    write_reg(sldr_pkg::CFG_BASE, 16'd5);
    run_random(RANDOM_ITEMS, 1'b0);

    // receiver idles less than sender, longest duration
    write_reg(sldr_pkg::CFG_DURATION, 16'hFFFF);
    write_reg(sldr_pkg::CFG_BASE, 16'd1);
    tx_idle_pct = 55;
    rx_idle_pct = 30;
    run_random(RANDOM_ITEMS, 1'b0);

    // no idling, long receiver hold, then a full pause and new settings
    write_reg(sldr_pkg::CFG_DURATION, 16'd1);
    write_reg(sldr_pkg::CFG_BASE, 16'd0);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_random(RANDOM_ITEMS / 2, 1'b1);
    write_reg(sldr_pkg::CFG_DURATION, 16'd0);
    write_reg(sldr_pkg::CFG_BASE, 16'hFFFF);
    run_random(RANDOM_ITEMS / 2, 1'b0);

    quiet_and_settle();
    if (pending_duty.size() != 0)
      note_error($sformatf("%0d expected items never arrived", pending_duty.size()));

    $display("covered %0d items and %0d checked results: %0d table steps, %0d ramp ends",
             items_sent, results_checked, ramp_updates, ramp_ends);
    $display("%0d register writes over durations 0..65535 min and periods 0..65535 ms",
             reg_writes);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== sunrise_led_dimming_ramp.f =====
hdl/sldr_pkg.sv
hdl/sldr_evt_if.sv
hdl/sldr_res_if.sv
hdl/sunrise_led_dimming_ramp.sv
tb/tb_sunrise_led_dimming_ramp.sv
